[sv/pfuv_pkg.sv]
// ----------------------------------------------------------------------------
// pfuv_pkg: shared types for the per-face planar UV block
// Holds the dominant axis code and the per-face control group that travels
// from the normal pipeline into the projection pipeline.
// ----------------------------------------------------------------------------
package pfuv_pkg;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    axis_t axis;
    logic  skipped;
  } face_ctl_t;

endpackage

[sv/pfuv_if.sv]
// ----------------------------------------------------------------------------
// pfuv interfaces: triangle input channel and UV result channel
// Each channel carries valid, ready and the payload; an item moves when both
// valid and ready are high at a rising clock edge.
// ----------------------------------------------------------------------------
interface pfuv_tri_if #(
  parameter int COORD_BITS = 16,
  parameter int INDEX_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] v0_x;
  logic signed [COORD_BITS-1:0] v0_y;
  logic signed [COORD_BITS-1:0] v0_z;
  logic signed [COORD_BITS-1:0] v1_x;
  logic signed [COORD_BITS-1:0] v1_y;
  logic signed [COORD_BITS-1:0] v1_z;
  logic signed [COORD_BITS-1:0] v2_x;
  logic signed [COORD_BITS-1:0] v2_y;
  logic signed [COORD_BITS-1:0] v2_z;
  logic        [INDEX_BITS-1:0] vertex0_index;
  logic        [INDEX_BITS-1:0] vertex1_index;
  logic        [INDEX_BITS-1:0] vertex2_index;

  modport source (
    output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
    output vertex0_index, vertex1_index, vertex2_index,
    input  ready
  );
  modport sink (
    input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
    input  vertex0_index, vertex1_index, vertex2_index,
    output ready
  );
endinterface

interface pfuv_uv_if #(
  parameter int UV_FRAC_BITS = 16,
  parameter int INDEX_BITS   = 16
);
  logic                  valid;
  logic                  ready;
  logic [UV_FRAC_BITS:0] uv0_u;
  logic [UV_FRAC_BITS:0] uv0_v;
  logic [UV_FRAC_BITS:0] uv1_u;
  logic [UV_FRAC_BITS:0] uv1_v;
  logic [UV_FRAC_BITS:0] uv2_u;
  logic [UV_FRAC_BITS:0] uv2_v;
  logic [INDEX_BITS-1:0] out_index0;
  logic [INDEX_BITS-1:0] out_index1;
  logic [INDEX_BITS-1:0] out_index2;
  logic                  face_skipped;

  modport source (
    output valid, uv0_u, uv0_v, uv1_u, uv1_v, uv2_u, uv2_v,
    output out_index0, out_index1, out_index2, face_skipped,
    input  ready
  );
  modport sink (
    input  valid, uv0_u, uv0_v, uv1_u, uv1_v, uv2_u, uv2_v,
    input  out_index0, out_index1, out_index2, face_skipped,
    output ready
  );
endinterface

[sv/per_face_planar_uv.sv]
// ----------------------------------------------------------------------------
// per_face_planar_uv: dominant-axis planar UV projection of one triangle
// Computes the face normal, picks the projection plane and scales each
// vertex into a rounded Q1.UV_FRAC_BITS UV within the face's bounding box.
// ----------------------------------------------------------------------------
// The block takes one triangle per clock cycle while the output is not
// stalled and returns one result item per triangle in input order: four
// stages form the cross product and pick the dominant axis, three project
// and form the dividend, and the restoring dividers retire one quotient bit
// per stage. Backpressure on the output stalls only the stages that are full,
// so bubbles are squeezed out.
module per_face_planar_uv
  import pfuv_pkg::*;
#(
  parameter int COORD_BITS   = 16,
  parameter int UV_FRAC_BITS = 16,
  parameter int INDEX_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst,
  pfuv_tri_if.sink  in,
  pfuv_uv_if.source out
);

  logic signed [COORD_BITS-1:0] crd_in [9];
  logic [2:0][INDEX_BITS-1:0]   idx_in;

  logic                         mid_valid;
  logic                         mid_ready;
  logic signed [COORD_BITS-1:0] mid_crd [9];
  logic [2:0][INDEX_BITS-1:0]   mid_idx;
  face_ctl_t                    mid_ctl;

  logic [UV_FRAC_BITS:0]        uv [6];
  logic [2:0][INDEX_BITS-1:0]   idx_out;

  // Gather the input fields into vertex-major order.
  assign crd_in[0] = in.v0_x;
  assign crd_in[1] = in.v0_y;
  assign crd_in[2] = in.v0_z;
  assign crd_in[3] = in.v1_x;
  assign crd_in[4] = in.v1_y;
  assign crd_in[5] = in.v1_z;
  assign crd_in[6] = in.v2_x;
  assign crd_in[7] = in.v2_y;
  assign crd_in[8] = in.v2_z;
  assign idx_in    = {in.vertex2_index, in.vertex1_index, in.vertex0_index};

  pfuv_cross #(
    .C (COORD_BITS),
    .I (INDEX_BITS)
  ) u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .in_crd    (crd_in),
    .in_idx    (idx_in),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_crd   (mid_crd),
    .out_idx   (mid_idx),
    .out_ctl   (mid_ctl)
  );

  pfuv_scale #(
    .C (COORD_BITS),
    .F (UV_FRAC_BITS),
    .I (INDEX_BITS)
  ) u_scale (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (mid_valid),
    .in_ready    (mid_ready),
    .in_crd      (mid_crd),
    .in_idx      (mid_idx),
    .in_ctl      (mid_ctl),
    .out_valid   (out.valid),
    .out_ready   (out.ready),
    .out_uv      (uv),
    .out_idx     (idx_out),
    .out_skipped (out.face_skipped)
  );

  // Spread the results onto the output fields.
  assign out.uv0_u      = uv[0];
  assign out.uv0_v      = uv[1];
  assign out.uv1_u      = uv[2];
  assign out.uv1_v      = uv[3];
  assign out.uv2_u      = uv[4];
  assign out.uv2_v      = uv[5];
  assign out.out_index0 = idx_out[0];
  assign out.out_index1 = idx_out[1];
  assign out.out_index2 = idx_out[2];

endmodule

[sv/pfuv_cross.sv]
// ----------------------------------------------------------------------------
// pfuv_cross: face normal and dominant axis pipeline
// Four stages: edge vectors, six partial products, normal components,
// magnitude compare. Coordinates and indices travel alongside.
// ----------------------------------------------------------------------------
module pfuv_cross
  import pfuv_pkg::*;
#(
  parameter int C = 16,
  parameter int I = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [C-1:0] in_crd [9],
  input  logic [2:0][I-1:0]   in_idx,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [C-1:0] out_crd [9],
  output logic [2:0][I-1:0]   out_idx,
  output face_ctl_t           out_ctl
);

  localparam int E  = C + 1;
  localparam int P  = 2 * E;
  localparam int NW = P + 1;
  localparam int S  = 4;

  logic [S-1:0] vld;
  logic [S-1:0] adv;

  logic signed [C-1:0] crd_s [S][9];
  logic [2:0][I-1:0]   idx_s [S];

  logic signed [E-1:0]  e1 [3];
  logic signed [E-1:0]  e2 [3];
  logic signed [P-1:0]  prod [6];
  logic signed [NW-1:0] nrm [3];
  logic                 nzero;
  face_ctl_t            ctl;

  logic [NW-1:0] mag [3];
  face_ctl_t     ctl_next;

  // Stall control: a stage moves when it is empty or the next one moves.
  always_comb begin
    adv[S-1] = !vld[S-1] || out_ready;
    for (int k = S - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int k = 1; k < S; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Side payload: coordinates and indices follow the item.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      crd_s[0] <= in_crd;
      idx_s[0] <= in_idx;
    end
    for (int k = 1; k < S; k++) begin
      if (adv[k]) begin
        crd_s[k] <= crd_s[k-1];
        idx_s[k] <= idx_s[k-1];
      end
    end
  end

  // Stage one: edge vectors from the first vertex.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] <= {in_crd[3+k][C-1], in_crd[3+k]} - {in_crd[k][C-1], in_crd[k]};
        e2[k] <= {in_crd[6+k][C-1], in_crd[6+k]} - {in_crd[k][C-1], in_crd[k]};
      end
    end
  end

  // Stage two: the six products of the cross product.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      prod[0] <= P'(e1[1] * e2[2]);
      prod[1] <= P'(e1[2] * e2[1]);
      prod[2] <= P'(e1[2] * e2[0]);
      prod[3] <= P'(e1[0] * e2[2]);
      prod[4] <= P'(e1[0] * e2[1]);
      prod[5] <= P'(e1[1] * e2[0]);
    end
  end

  // Stage three: normal components.
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int k = 0; k < 3; k++) begin
        nrm[k] <= {prod[2*k][P-1], prod[2*k]} - {prod[2*k+1][P-1], prod[2*k+1]};
      end
    end
  end

  // Stage four: magnitudes, zero test and dominant axis with ties to x then y.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = nrm[k][NW-1] ? (~nrm[k] + 1'b1) : nrm[k];
    end
    nzero = (nrm[0] == '0) && (nrm[1] == '0) && (nrm[2] == '0);
    if (mag[0] >= mag[1] && mag[0] >= mag[2]) begin
      ctl_next.axis = AXIS_X;
    end else if (mag[1] >= mag[2]) begin
      ctl_next.axis = AXIS_Y;
    end else begin
      ctl_next.axis = AXIS_Z;
    end
    ctl_next.skipped = nzero;
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      ctl <= ctl_next;
    end
  end

  assign out_valid = vld[S-1];
  assign out_crd   = crd_s[S-1];
  assign out_idx   = idx_s[S-1];
  assign out_ctl   = ctl;

endmodule

[sv/pfuv_scale.sv]
// ----------------------------------------------------------------------------
// pfuv_scale: planar projection and UV scaling pipeline
// Selects the two projection axes, takes per-axis minimum and extent, and
// runs six restoring dividers, one quotient bit per stage, for rounded UVs.
// ----------------------------------------------------------------------------
module pfuv_scale
  import pfuv_pkg::*;
#(
  parameter int C = 16,
  parameter int F = 16,
  parameter int I = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [C-1:0] in_crd [9],
  input  logic [2:0][I-1:0]   in_idx,
  input  face_ctl_t           in_ctl,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [F:0]          out_uv [6],
  output logic [2:0][I-1:0]   out_idx,
  output logic                out_skipped
);

  localparam int FR = 3;
  localparam int S  = FR + F + 1;
  localparam int W  = C + F + 2;
  localparam int R  = C + 1;

  logic [S-1:0] vld;
  logic [S-1:0] adv;

  logic [2:0][I-1:0] idx_s  [S];
  logic              skip_s [S];

  // Front stages.
  logic signed [C-1:0] pc [6];
  logic signed [C-1:0] pc2 [6];
  logic signed [C-1:0] mn [2];
  logic signed [C-1:0] mx [2];

  logic signed [C-1:0] mn_next [2];
  logic signed [C-1:0] mx_next [2];
  logic [C-1:0]        offs [6];
  logic [C-1:0]        ext  [2];
  logic [C:0]          ext_raw [2];
  logic [W-1:0]        num  [6];

  // Divider stages: partial remainder, unused dividend bits, divisor, quotient.
  logic [R-1:0] rem  [S][6];
  logic [F:0]   low  [S][6];
  logic [R-1:0] dvs  [S][2];
  logic [F:0]   quo  [S][6];

  always_comb begin
    adv[S-1] = !vld[S-1] || out_ready;
    for (int k = S - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int k = 1; k < S; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Indices and the skip flag follow the item.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      idx_s[0]  <= in_idx;
      skip_s[0] <= in_ctl.skipped;
    end
    for (int k = 1; k < S; k++) begin
      if (adv[k]) begin
        idx_s[k]  <= idx_s[k-1];
        skip_s[k] <= skip_s[k-1];
      end
    end
  end

  // Stage one: pick u and v coordinates for each vertex.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < 3; i++) begin
        pc[2*i]   <= (in_ctl.axis == AXIS_X) ? in_crd[3*i+1] : in_crd[3*i];
        pc[2*i+1] <= (in_ctl.axis == AXIS_Z) ? in_crd[3*i+1] : in_crd[3*i+2];
      end
    end
  end

  // Stage two: per-axis minimum and maximum.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      mn_next[k] = pc[k];
      mx_next[k] = pc[k];
      for (int i = 1; i < 3; i++) begin
        if (pc[2*i+k] < mn_next[k]) mn_next[k] = pc[2*i+k];
        if (pc[2*i+k] > mx_next[k]) mx_next[k] = pc[2*i+k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      pc2 <= pc;
      mn  <= mn_next;
      mx  <= mx_next;
    end
  end

  // Stage three: offsets, extent floored to one, and the rounded dividend.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      ext_raw[k] = {mx[k][C-1], mx[k]} - {mn[k][C-1], mn[k]};
      ext[k]     = (ext_raw[k][C-1:0] == '0) ? C'(1) : ext_raw[k][C-1:0];
    end
    for (int l = 0; l < 6; l++) begin
      offs[l] = C'({pc2[l][C-1], pc2[l]} - {mn[l%2][C-1], mn[l%2]});
      num[l]  = {1'b0, offs[l], {(F + 1){1'b0}}} + W'(ext[l%2]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int l = 0; l < 6; l++) begin
        rem[FR-1][l] <= num[l][W-1:F+1];
        low[FR-1][l] <= num[l][F:0];
        quo[FR-1][l] <= '0;
      end
      for (int k = 0; k < 2; k++) begin
        dvs[FR-1][k] <= {ext[k], 1'b0};
      end
    end
  end

  // Divider stages: one quotient bit per stage, most significant first.
  for (genvar j = 0; j <= F; j++) begin : g_div
    logic [R:0] trial [6];
    logic       take  [6];

    always_comb begin
      for (int l = 0; l < 6; l++) begin
        trial[l] = {rem[FR-1+j][l], low[FR-1+j][l][F-j]};
        take[l]  = trial[l] >= {1'b0, dvs[FR-1+j][l%2]};
      end
    end

    always_ff @(posedge clk) begin
      if (adv[FR+j]) begin
        for (int l = 0; l < 6; l++) begin
          rem[FR+j][l] <= take[l] ? R'(trial[l] - {1'b0, dvs[FR-1+j][l%2]})
                                  : R'(trial[l]);
          low[FR+j][l] <= low[FR-1+j][l];
          quo[FR+j][l] <= {quo[FR-1+j][l][F-1:0], take[l]};
        end
        dvs[FR+j] <= dvs[FR-1+j];
      end
    end
  end

  // A skipped face reports all UVs as zero.
  always_comb begin
    for (int l = 0; l < 6; l++) begin
      out_uv[l] = skip_s[S-1] ? '0 : quo[S-1][l];
    end
  end

  assign out_valid   = vld[S-1];
  assign out_idx     = idx_s[S-1];
  assign out_skipped = skip_s[S-1];

endmodule

[test/per_face_planar_uv_tb.sv]
// ----------------------------------------------------------------------------
// per_face_planar_uv_tb: self-checking bench for the per-face planar UV block
// Streams triangles through the block under random idling on both channels
// and checks every result against a behavioral computation of the projection.
// ----------------------------------------------------------------------------
module per_face_planar_uv_tb;
  import pfuv_pkg::*;

  localparam int CB = 16;
  localparam int UFB = 16;
  localparam int IB = 16;
  localparam int NUM_RANDOM = 640;
  localparam int STALL_LIMIT = 20000;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    coord_t        c [3][3];
    logic [IB-1:0] idx [3];
  } tri_t;

  typedef struct {
    logic [UFB:0]  uv [3][2];
    logic [IB-1:0] idx [3];
    logic          skipped;
  } uv_res_t;

  logic clk;
  logic rst;

  pfuv_tri_if #(.COORD_BITS(CB), .INDEX_BITS(IB)) tri_ch ();
  pfuv_uv_if #(.UV_FRAC_BITS(UFB), .INDEX_BITS(IB)) uv_ch ();

  per_face_planar_uv #(
    .COORD_BITS(CB), .UV_FRAC_BITS(UFB), .INDEX_BITS(IB)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in(tri_ch.sink),
    .out(uv_ch.source)
  );

  tri_t    pending_tris [$];
  uv_res_t expected_uvs [$];
  int      send_idle_pct;
  int      recv_idle_pct;
  int      fail_count;
  int      quiet_cycles;

  // Projects one triangle: exact normal, dominant axis, rounded UV.
  function automatic uv_res_t project_face(tri_t t);
    uv_res_t r;
    longint  e1 [3];
    longint  e2 [3];
    longint  n [3];
    longint  an [3];
    longint  mn, mx, ext, d;
    int      axes [2];
    for (int i = 0; i < 3; i++) begin
      r.idx[i] = t.idx[i];
      r.uv[i][0] = '0;
      r.uv[i][1] = '0;
    end
    for (int k = 0; k < 3; k++) begin
      e1[k] = longint'(t.c[1][k]) - longint'(t.c[0][k]);
      e2[k] = longint'(t.c[2][k]) - longint'(t.c[0][k]);
    end
    // Edges fit in 17 bits, so products and the normal fit in 64 bits.
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    r.skipped = (n[0] == 0) && (n[1] == 0) && (n[2] == 0);
    if (r.skipped) return r;
    for (int k = 0; k < 3; k++) an[k] = (n[k] < 0) ? -n[k] : n[k];
    if (an[0] >= an[1] && an[0] >= an[2]) begin
      axes[0] = 1; axes[1] = 2;
    end else if (an[1] >= an[2]) begin
      axes[0] = 0; axes[1] = 2;
    end else begin
      axes[0] = 0; axes[1] = 1;
    end
    for (int k = 0; k < 2; k++) begin
      mn = t.c[0][axes[k]];
      mx = mn;
      for (int i = 1; i < 3; i++) begin
        if (t.c[i][axes[k]] < mn) mn = t.c[i][axes[k]];
        if (t.c[i][axes[k]] > mx) mx = t.c[i][axes[k]];
      end
      ext = (mx - mn < 1) ? 1 : mx - mn;
      for (int i = 0; i < 3; i++) begin
        d = longint'(t.c[i][axes[k]]) - mn;
        r.uv[i][k] = (UFB + 1)'(((d << (UFB + 1)) + ext) / (2 * ext));
      end
    end
    return r;
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) t.c[i][k] = coord_t'($urandom);
      t.idx[i] = IB'($urandom);
    end
    return t;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Driver: presents the oldest pending triangle, idling at random.
  // The expected result is queued when the block accepts the triangle.
  always @(posedge clk) begin
    if (rst) begin
      tri_ch.valid <= 1'b0;
    end else begin
      if (tri_ch.valid && tri_ch.ready) begin
        expected_uvs.push_back(project_face(pending_tris[0]));
        void'(pending_tris.pop_front());
      end
      if (!tri_ch.valid || tri_ch.ready) begin
        if (pending_tris.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          tri_t t;
          t = pending_tris[0];
          tri_ch.valid <= 1'b1;
          tri_ch.v0_x <= t.c[0][0]; tri_ch.v0_y <= t.c[0][1]; tri_ch.v0_z <= t.c[0][2];
          tri_ch.v1_x <= t.c[1][0]; tri_ch.v1_y <= t.c[1][1]; tri_ch.v1_z <= t.c[1][2];
          tri_ch.v2_x <= t.c[2][0]; tri_ch.v2_y <= t.c[2][1]; tri_ch.v2_z <= t.c[2][2];
          tri_ch.vertex0_index <= t.idx[0];
          tri_ch.vertex1_index <= t.idx[1];
          tri_ch.vertex2_index <= t.idx[2];
        end else begin
          tri_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure and field-by-field comparison.
  always @(posedge clk) begin
    if (rst) begin
      uv_ch.ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      uv_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if ((tri_ch.valid && tri_ch.ready) || (uv_ch.valid && uv_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (uv_ch.valid && uv_ch.ready) begin
        if (expected_uvs.size() == 0) begin
          $display("%0t: unexpected result item, expected none, got idx %0d %0d %0d",
                   $time, uv_ch.out_index0, uv_ch.out_index1, uv_ch.out_index2);
          fail_count++;
        end else begin
          uv_res_t e;
          logic [UFB:0] got_uv [3][2];
          logic [IB-1:0] got_idx [3];
          e = expected_uvs.pop_front();
          got_uv[0][0] = uv_ch.uv0_u; got_uv[0][1] = uv_ch.uv0_v;
          got_uv[1][0] = uv_ch.uv1_u; got_uv[1][1] = uv_ch.uv1_v;
          got_uv[2][0] = uv_ch.uv2_u; got_uv[2][1] = uv_ch.uv2_v;
          got_idx[0] = uv_ch.out_index0;
          got_idx[1] = uv_ch.out_index1;
          got_idx[2] = uv_ch.out_index2;
          for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 2; k++) begin
              if (got_uv[i][k] !== e.uv[i][k]) begin
                $display("%0t: uv%0d %s expected %0d actual %0d", $time, i,
                         k == 0 ? "u" : "v", e.uv[i][k], got_uv[i][k]);
                fail_count++;
              end
            end
            if (got_idx[i] !== e.idx[i]) begin
              $display("%0t: out_index%0d expected %0d actual %0d", $time, i,
                       e.idx[i], got_idx[i]);
              fail_count++;
            end
          end
          if (uv_ch.face_skipped !== e.skipped) begin
            $display("%0t: face_skipped expected %0b actual %0b", $time, e.skipped,
                     uv_ch.face_skipped);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item.
  always @(posedge clk) begin
    if (!rst && quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    tri_t t;
    fail_count = 0;
    send_idle_pct = 28;
    recv_idle_pct = 75;
    rst = 1'b1;
    tri_ch.valid = 1'b0;
    uv_ch.ready = 1'b0;
    {tri_ch.v0_x, tri_ch.v0_y, tri_ch.v0_z} = '0;
    {tri_ch.v1_x, tri_ch.v1_y, tri_ch.v1_z} = '0;
    {tri_ch.v2_x, tri_ch.v2_y, tri_ch.v2_z} = '0;
    {tri_ch.vertex0_index, tri_ch.vertex1_index, tri_ch.vertex2_index} = '0;

    // Directed triangles: degenerate faces, each dominant axis, ties,
    // coordinate extremes and zero extent on one axis.
    t.idx = '{16'h0000, 16'hFFFF, 16'h5A5A};
    t.c = '{'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}};                 pending_tris.push_back(t);
    t.c = '{'{1, 2, 3}, '{2, 4, 6}, '{3, 6, 9}};                 pending_tris.push_back(t);
    t.c = '{'{0, 0, 0}, '{0, 256, 0}, '{0, 0, 256}};             pending_tris.push_back(t);
    t.c = '{'{0, 0, 0}, '{256, 0, 0}, '{0, 0, 256}};             pending_tris.push_back(t);
    t.c = '{'{0, 0, 0}, '{256, 0, 0}, '{0, 256, 0}};             pending_tris.push_back(t);
    t.c = '{'{0, 0, 0}, '{256, 0, 0}, '{0, 256, 256}};           pending_tris.push_back(t);
    t.c = '{'{0, 0, 0}, '{256, 256, 0}, '{256, 0, 256}};         pending_tris.push_back(t);
    t.c = '{'{0, 0, 0}, '{0, 256, 0}, '{256, 0, 256}};           pending_tris.push_back(t);
    t.idx = '{16'hFFFF, 16'h0000, 16'h8001};
    t.c = '{'{-32768, -32768, -32768}, '{32767, -32768, 32767}, '{-32768, 32767, 32767}};
    pending_tris.push_back(t);
    t.c = '{'{32767, 32767, 32767}, '{-32768, 32767, -32768}, '{32767, -32768, -32768}};
    pending_tris.push_back(t);
    t.c = '{'{-32768, 0, 32767}, '{32767, 0, -32768}, '{0, 0, 0}};
    pending_tris.push_back(t);
    t.c = '{'{5, 7, 100}, '{9, 7, 100}, '{5, 8, 101}};            pending_tris.push_back(t);
    t.c = '{'{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}};                 pending_tris.push_back(t);
    t.c = '{'{0, 0, 0}, '{3, 0, 0}, '{0, 0, 1}};                 pending_tris.push_back(t);
    t.c = '{'{-1, -1, -1}, '{-32768, -1, -32768}, '{-1, -32768, -1}};
    pending_tris.push_back(t);
    t.c = '{'{100, -200, 300}, '{-32768, 32767, 0}, '{32767, 32767, -32768}};
    pending_tris.push_back(t);

    // Random faces: mostly full range, some small, some degenerate lines.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      t = rand_tri();
      case ($urandom_range(9))
        0, 1: begin
          for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
              t.c[i][k] = coord_t'($urandom_range(15)) - coord_t'(8);
        end
        2: begin
          for (int k = 0; k < 3; k++) t.c[2][k] = t.c[$urandom_range(1)][k];
        end
        3: begin
          for (int k = 0; k < 3; k++) t.c[1][k] = t.c[0][$urandom_range(0)];
          t.c[1][$urandom_range(2)] = t.c[1][$urandom_range(2)];
          t.c[2][$urandom_range(2)] = t.c[0][$urandom_range(2)];
        end
        default: ;
      endcase
      pending_tris.push_back(t);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Idling phases: receiver heavy, then sender heavy, then none.
    wait (pending_tris.size() <= 2 * NUM_RANDOM / 3);
    @(posedge clk);
    send_idle_pct = 75;
    recv_idle_pct = 28;
    wait (pending_tris.size() <= NUM_RANDOM / 3);
    @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait (pending_tris.size() == 0);
    wait (expected_uvs.size() == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
sv/pfuv_pkg.sv
sv/pfuv_if.sv
sv/pfuv_cross.sv
sv/pfuv_scale.sv
sv/per_face_planar_uv.sv
test/per_face_planar_uv_tb.sv
